// File: sv/indexed_insert_erase_array_defines.svh
// assertion macros used by the checker file
`ifndef INDEXED_INSERT_ERASE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_ERASE_ARRAY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define IIEA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iiea assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define IIEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iiea assertion failed");

`endif

// File: sv/iiea_pkg.sv
package iiea_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_ELEM_WIDTH = 32;

  // fixed port widths
  localparam int OP_W   = 4;
  localparam int IDX_W  = 7;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;

  // position width wide enough for the largest capacity plus one
  localparam int POS_W = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 4'd1;
  localparam logic [OP_W-1:0] OP_SET    = 4'd2;
  localparam logic [OP_W-1:0] OP_READ   = 4'd3;
  localparam logic [OP_W-1:0] OP_PUSH   = 4'd4;
  localparam logic [OP_W-1:0] OP_POP    = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd6;
  localparam logic [OP_W-1:0] OP_RESIZE = 4'd7;
  localparam logic [OP_W-1:0] OP_FRONT  = 4'd8;
  localparam logic [OP_W-1:0] OP_BACK   = 4'd9;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             snap;
    logic             shift_rd;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] wr_lo;
    logic [POS_W-1:0] wr_hi;
  } cell_ctrl_t;

endpackage

// File: sv/indexed_insert_erase_array.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------
// in       | in_valid / in_ready    | op, index, value, new_length
// out      | out_valid / out_ready  | read_data, length, status
//
// insert, erase, set, push, pop, clear and resize act on all cells at once: every cell
// loads from itself, its neighbour or the write value in parallel
// read, front and back walk the element out: the cells' read lane is loaded
// from the cells and shifts one place per cycle towards cell zero
// one transaction is in work at a time; a new one is taken while the result
// register is free or being emptied
// rst (synchronous) clears the fill count and the sequencer; cell contents
// are left as they are, since no position at or above the count is read
module indexed_insert_erase_array #(
  parameter int CAPACITY   = iiea_pkg::DEF_CAPACITY,
  parameter int ELEM_WIDTH = iiea_pkg::DEF_ELEM_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [iiea_pkg::OP_W-1:0]    op,
  input  logic [iiea_pkg::IDX_W-1:0]   index,
  input  logic [iiea_pkg::DATA_W-1:0]  value,
  input  logic [iiea_pkg::IDX_W-1:0]   new_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iiea_pkg::DATA_W-1:0]  read_data,
  output logic [iiea_pkg::LEN_W-1:0]   length,
  output logic [iiea_pkg::ST_W-1:0]    status
);

  localparam int PW  = iiea_pkg::POS_W;
  localparam int DW  = iiea_pkg::DATA_W;
  localparam int LW  = iiea_pkg::LEN_W;
  localparam int SW  = iiea_pkg::ST_W;
  localparam int CW  = $clog2(CAPACITY + 1);  // fill count width
  localparam int AW  = $clog2(CAPACITY);      // cell position width
  localparam int EW  = ELEM_WIDTH;

  localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

  // sequencer codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] rcnt;

  logic                 acc;
  logic                 rd_start;
  logic [AW-1:0]        rd_pos;
  logic [SW-1:0]        st;
  iiea_pkg::cell_ctrl_t op_ctrl;
  iiea_pkg::cell_ctrl_t cell_ctrl;

  logic [PW-1:0] idx_x;
  logic [PW-1:0] n_x;
  logic [PW-1:0] nlen_x;

  logic [EW-1:0] wval;
  logic [DW-1:0] rd_word;
  logic [EW-1:0] cell_data [CAPACITY];
  logic [EW-1:0] cell_rd   [CAPACITY];

  logic [DW-1:0] read_data_q;
  logic [LW-1:0] length_q;
  logic [SW-1:0] status_q;

  // ready only while no read is walking and the result slot can be refilled
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  assign idx_x  = PW'(index);
  assign n_x    = PW'(count);
  assign nlen_x = PW'(new_length);

  // value masked to the element width, element widened or cut to the port
  for (genvar b = 0; b < EW; b++) begin : g_wval
    if (b < DW) begin : g_in
      assign wval[b] = value[b];
    end else begin : g_pad
      assign wval[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < DW; b++) begin : g_rdw
    if (b < EW) begin : g_in
      assign rd_word[b] = cell_rd[0][b];
    end else begin : g_pad
      assign rd_word[b] = 1'b0;
    end
  end

  // operation decode: range and capacity checks, cell control, new count
  always_comb begin
    op_ctrl    = '0;
    st         = iiea_pkg::ST_OK;
    count_next = count;
    rd_start   = 1'b0;
    rd_pos     = '0;
    case (op)
      iiea_pkg::OP_INSERT: begin
        if (idx_x > n_x) begin
          st = iiea_pkg::ST_RANGE;
        end else if (n_x >= CAP_X) begin
          st = iiea_pkg::ST_FULL;
        end else begin
          op_ctrl.shift_up = 1'b1;
          op_ctrl.pos      = idx_x;
          op_ctrl.wr_lo    = idx_x;
          op_ctrl.wr_hi    = PW'(idx_x + 1'b1);
          count_next       = CW'(count + 1'b1);
        end
      end
      iiea_pkg::OP_ERASE: begin
        if (idx_x >= n_x) begin
          st = iiea_pkg::ST_RANGE;
        end else begin
          op_ctrl.shift_down = 1'b1;
          op_ctrl.pos        = idx_x;
          count_next         = CW'(count - 1'b1);
        end
      end
      iiea_pkg::OP_SET: begin
        if (idx_x >= n_x) begin
          st = iiea_pkg::ST_RANGE;
        end else begin
          op_ctrl.wr_lo = idx_x;
          op_ctrl.wr_hi = PW'(idx_x + 1'b1);
        end
      end
      iiea_pkg::OP_READ: begin
        if (idx_x >= n_x) begin
          st = iiea_pkg::ST_RANGE;
        end else begin
          rd_start = 1'b1;
          rd_pos   = AW'(idx_x);
        end
      end
      iiea_pkg::OP_PUSH: begin
        if (n_x >= CAP_X) begin
          st = iiea_pkg::ST_FULL;
        end else begin
          op_ctrl.wr_lo = n_x;
          op_ctrl.wr_hi = PW'(n_x + 1'b1);
          count_next    = CW'(count + 1'b1);
        end
      end
      iiea_pkg::OP_POP: begin
        if (count == '0) begin
          st = iiea_pkg::ST_EMPTY;
        end else begin
          count_next = CW'(count - 1'b1);
        end
      end
      iiea_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      iiea_pkg::OP_RESIZE: begin
        if (nlen_x > CAP_X) begin
          st = iiea_pkg::ST_FULL;
        end else begin
          // growing fills the new positions, shrinking leaves an empty range
          op_ctrl.wr_lo = n_x;
          op_ctrl.wr_hi = nlen_x;
          count_next    = CW'(nlen_x);
        end
      end
      iiea_pkg::OP_FRONT: begin
        if (count == '0) begin
          st = iiea_pkg::ST_EMPTY;
        end else begin
          rd_start = 1'b1;
        end
      end
      iiea_pkg::OP_BACK: begin
        if (count == '0) begin
          st = iiea_pkg::ST_EMPTY;
        end else begin
          rd_start = 1'b1;
          rd_pos   = AW'(n_x - 1'b1);
        end
      end
      default: begin
        // unused codes leave everything alone and report ok
      end
    endcase
  end

  // cells only see an operation in the cycle its transaction is taken
  always_comb begin
    cell_ctrl          = acc ? op_ctrl : '0;
    cell_ctrl.snap     = acc && rd_start;
    cell_ctrl.shift_rd = (state == S_READ) && (rcnt != '0);
  end

  // row of cells, each wired to its two neighbours
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    logic [EW-1:0] right_r;

    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_d = '0;
      assign right_r = '0;
    end else begin : g_inner
      assign right_d = cell_data[k+1];
      assign right_r = cell_rd[k+1];
    end

    iiea_cell #(
      .POS (k),
      .EW  (EW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .wval       (wval),
      .left_data  (left_d),
      .right_data (right_d),
      .right_rd   (right_r),
      .data       (cell_data[k]),
      .rd         (cell_rd[k])
    );
  end

  // sequencer and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
        if (rd_start) begin
          state     <= S_READ;
          rcnt      <= rd_pos;
          out_valid <= 1'b0;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (state == S_READ) begin
        // the wanted element has reached cell zero
        if (rcnt == '0) begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end else begin
          rcnt <= rcnt - 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: length and status known at once, read data at the end
  always_ff @(posedge clk) begin
    if (acc) begin
      length_q    <= LW'(count_next);
      status_q    <= st;
      read_data_q <= '0;
    end else if ((state == S_READ) && (rcnt == '0)) begin
      read_data_q <= rd_word;
    end
  end

  assign read_data = read_data_q;
  assign length    = length_q;
  assign status    = status_q;

endmodule

// File: sv/iiea_cell.sv
module iiea_cell #(
  parameter int POS = 0,
  parameter int EW  = iiea_pkg::DEF_ELEM_WIDTH
) (
  input  logic                 clk,
  input  iiea_pkg::cell_ctrl_t ctrl,
  input  logic [EW-1:0]        wval,
  input  logic [EW-1:0]        left_data,
  input  logic [EW-1:0]        right_data,
  input  logic [EW-1:0]        right_rd,
  output logic [EW-1:0]        data,
  output logic [EW-1:0]        rd
);

  localparam int PW = iiea_pkg::POS_W;
  localparam logic [PW-1:0] MY_POS = PW'(POS);

  logic hit;

  assign hit = (MY_POS >= ctrl.wr_lo) && (MY_POS < ctrl.wr_hi);

  always_ff @(posedge clk) begin
    if (hit) begin
      data <= wval;
    end else if (ctrl.shift_up && (MY_POS > ctrl.pos)) begin
      data <= left_data;
    end else if (ctrl.shift_down && (MY_POS >= ctrl.pos)) begin
      data <= right_data;
    end
    // read lane moves one place towards cell zero per cycle while shift_rd is set
    if (ctrl.snap) begin
      rd <= data;
    end else if (ctrl.shift_rd) begin
      rd <= right_rd;
    end
  end

endmodule

// File: sv/iiea_checker.sv
`include "indexed_insert_erase_array_defines.svh"

module iiea_checker #(
  parameter int CAPACITY = iiea_pkg::DEF_CAPACITY
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [iiea_pkg::OP_W-1:0]    op,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [iiea_pkg::DATA_W-1:0]  read_data,
  input logic [iiea_pkg::LEN_W-1:0]   length,
  input logic [iiea_pkg::ST_W-1:0]    status
);

  // a held result keeps its payload
  `IIEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(length) && $stable(status))

  // no new transaction while a result is stalled
  `IIEA_ASSERT_NOW(a_no_take_stalled, out_valid && !out_ready, !in_ready)

  // a faulty transaction returns zero data
  `IIEA_ASSERT_NOW(a_fault_zero, out_valid && (status != iiea_pkg::ST_OK), read_data == '0)

  // clear answers in the next cycle with an empty array
  `IIEA_ASSERT_NEXT(a_clear, in_valid && in_ready && (op == iiea_pkg::OP_CLEAR), out_valid && (length == '0) && (status == iiea_pkg::ST_OK))

  // length never passes the capacity
  `IIEA_ASSERT_NOW(a_len_cap, out_valid, (CAPACITY > 127) || (length <= CAPACITY))

endmodule

bind indexed_insert_erase_array iiea_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

// File: tb/tb_indexed_insert_erase_array.sv
`timescale 1ns / 1ps

module tb_indexed_insert_erase_array;
  import iiea_pkg::*;

  localparam int CAP = DEF_CAPACITY;

  // op codes above back are spare: the block must leave its state alone
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_BACK + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = {OP_W{1'b1}};

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [IDX_W-1:0]  IDX_MAX  = {IDX_W{1'b1}};

  // longest read walks the full read lane, so allow a little over that
  localparam int DRAIN_CYCLES = CAP + 40;
  localparam int RANDOM_OPS   = 650;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  new_length;
  } op_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  length;
    logic [ST_W-1:0]   status;
  } reply_t;

  // clock, reset and every block input known from time zero
  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op         = OP_CLEAR;
  logic [IDX_W-1:0]  index      = '0;
  logic [DATA_W-1:0] value      = '0;
  logic [IDX_W-1:0]  new_length = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic [LEN_W-1:0]  length;
  logic [ST_W-1:0]   status;

  // shadow copy of the array contents and fill count
  logic [DATA_W-1:0] shadow_cells [CAP];
  int unsigned       shadow_len = 0;

  op_item_t    op_backlog [$];   // transactions waiting for the driver
  reply_t      reply_q [$];      // replies owed by the block, oldest first
  op_item_t    drv_item;
  reply_t      want;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned err_cnt    = 0;
  logic [31:0] cycle_cnt  = '0;

  indexed_insert_erase_array u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .index      (index),
    .value      (value),
    .new_length (new_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .length     (length),
    .status     (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // idle length: mostly none or short, now and then long; a quarter of the
  // time both sides run flat out so back-to-back traffic is seen as well
  function automatic int unsigned pick_gap();
    int unsigned r;
    begin
      r = $urandom_range(0, 99);
      if (cycle_cnt[10:9] == 2'b00) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    begin
      $display("error at %0t ns: %s", $time, msg);
      err_cnt++;
    end
  endtask

  task automatic queue_op(input logic [OP_W-1:0] o, input int unsigned idx,
                          input logic [DATA_W-1:0] v, input int unsigned nlen);
    op_item_t it;
    begin
      it.op         = o;
      it.index      = IDX_W'(idx);
      it.value      = v;
      it.new_length = IDX_W'(nlen);
      op_backlog.insert(op_backlog.size(), it);
    end
  endtask

  // works out the reply to one transaction and moves the shadow array on;
  // a faulty transaction leaves contents and count untouched
  task automatic apply_array_op(input op_item_t it, output reply_t rep);
    int unsigned n;
    int unsigned idx;
    int unsigned nlen;
    int unsigned i;
    begin
      rep        = '0;
      rep.status = ST_OK;
      n          = shadow_len;
      idx        = 32'(it.index);
      nlen       = 32'(it.new_length);
      case (it.op)
        OP_INSERT: begin
          // range check wins over the full check
          if (idx > n) begin
            rep.status = ST_RANGE;
          end else if (n >= CAP) begin
            rep.status = ST_FULL;
          end else begin
            for (i = n; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[idx] = it.value;
            shadow_len = n + 1;
          end
        end
        OP_ERASE: begin
          if (idx >= n) begin
            rep.status = ST_RANGE;
          end else begin
            for (i = idx + 1; i < n; i++) shadow_cells[i-1] = shadow_cells[i];
            shadow_len = n - 1;
          end
        end
        OP_SET: begin
          if (idx >= n) rep.status = ST_RANGE;
          else shadow_cells[idx] = it.value;
        end
        OP_READ: begin
          if (idx >= n) rep.status = ST_RANGE;
          else rep.read_data = shadow_cells[idx];
        end
        OP_PUSH: begin
          if (n >= CAP) begin
            rep.status = ST_FULL;
          end else begin
            shadow_cells[n] = it.value;
            shadow_len = n + 1;
          end
        end
        OP_POP: begin
          if (n == 0) rep.status = ST_EMPTY;
          else shadow_len = n - 1;
        end
        OP_CLEAR: begin
          shadow_len = 0;
        end
        OP_RESIZE: begin
          // growing fills the new tail, shrinking only drops the count
          if (nlen > CAP) begin
            rep.status = ST_FULL;
          end else begin
            for (i = n; i < nlen; i++) shadow_cells[i] = it.value;
            shadow_len = nlen;
          end
        end
        OP_FRONT: begin
          if (n == 0) rep.status = ST_EMPTY;
          else rep.read_data = shadow_cells[0];
        end
        OP_BACK: begin
          if (n == 0) rep.status = ST_EMPTY;
          else rep.read_data = shadow_cells[n-1];
        end
        default: begin
        end
      endcase
      rep.length = LEN_W'(shadow_len);
    end
  endtask

  // driver: each accepted transaction is predicted on the edge that takes it,
  // then the next one is presented after a random gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_array_op(drv_item, want);
        reply_q.insert(reply_q.size(), want);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          drv_item   = op_backlog.pop_front();
          op         <= drv_item.op;
          index      <= drv_item.index;
          value      <= drv_item.value;
          new_length <= drv_item.new_length;
          in_valid   <= 1'b1;
          gap_left   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: each reply taken is checked against the oldest owed one,
  // while ready is dropped at random to back-pressure the result register
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("reply with no transaction outstanding");
        end else begin
          want = reply_q.pop_front();
          if (read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, predicted %h",
                                      read_data, want.read_data));
          if (length !== want.length)
            report_mismatch($sformatf("length %0d, predicted %0d",
                                      length, want.length));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      status, want.status));
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // stimulus
  initial begin
    op_item_t    it;
    int unsigned n;
    int unsigned r;
    int unsigned k;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: everything on an empty array first
    queue_op(OP_READ,   0, '0, 0);                   // read when empty
    queue_op(OP_ERASE,  0, '0, 0);                   // erase when empty
    queue_op(OP_SET,    0, ALL_ONES, 0);             // set when empty
    queue_op(OP_POP,    0, '0, 0);                   // pop when empty
    queue_op(OP_FRONT,  0, '0, 0);                   // front when empty
    queue_op(OP_BACK,   0, '0, 0);                   // back when empty
    queue_op(OP_INSERT, 1, ALL_ONES, 0);             // insert past the end
    queue_op(OP_SPARE_HI, IDX_MAX, ALL_ONES, IDX_MAX); // spare code
    queue_op(OP_SPARE_LO, 0, '0, 0);
    // build a short array and move it around
    queue_op(OP_INSERT, 0, ALL_ONES, 0);
    queue_op(OP_PUSH,   0, '0, 0);
    queue_op(OP_INSERT, 2, 32'ha5a5_a5a5, 0);        // insert at the end
    queue_op(OP_INSERT, 0, 32'h1234_5678, 0);        // insert at the front
    queue_op(OP_READ,   1, '0, 0);
    queue_op(OP_ERASE,  1, '0, 0);                   // erase from the middle
    queue_op(OP_SET,    0, 32'h0f0f_0f0f, 0);
    // resize beyond capacity, then grow to full
    queue_op(OP_RESIZE, 0, '0, CAP + 1);
    queue_op(OP_RESIZE, 0, '0, IDX_MAX);
    queue_op(OP_RESIZE, 0, 32'h5a5a_5a5a, CAP);
    queue_op(OP_PUSH,   0, ALL_ONES, 0);             // push when full
    queue_op(OP_INSERT, CAP, ALL_ONES, 0);           // insert when full
    queue_op(OP_INSERT, CAP + 1, ALL_ONES, 0);       // range beats full
    queue_op(OP_READ,   CAP - 1, '0, 0);             // deepest read
    queue_op(OP_BACK,   0, '0, 0);
    queue_op(OP_READ,   CAP, '0, 0);
    queue_op(OP_RESIZE, 0, ALL_ONES, 3);             // shrink
    queue_op(OP_CLEAR,  0, '0, 0);

    // random: mostly in-range indices against the current length,
    // with a share of wild ones and spare codes mixed in
    for (k = 0; k < RANDOM_OPS; k++) begin
      while (op_backlog.size() >= 2) @(negedge clk);
      n = shadow_len;
      r = $urandom_range(0, 99);
      if      (r < 15) it.op = OP_INSERT;
      else if (r < 27) it.op = OP_ERASE;
      else if (r < 37) it.op = OP_SET;
      else if (r < 52) it.op = OP_READ;
      else if (r < 69) it.op = OP_PUSH;
      else if (r < 77) it.op = OP_POP;
      else if (r < 79) it.op = OP_CLEAR;
      else if (r < 85) it.op = OP_RESIZE;
      else if (r < 91) it.op = OP_FRONT;
      else if (r < 97) it.op = OP_BACK;
      else it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

      r = $urandom_range(0, 99);
      if (r < 80) begin
        if (it.op == OP_INSERT) it.index = IDX_W'($urandom_range(0, n));
        else if (n != 0)        it.index = IDX_W'($urandom_range(0, n - 1));
        else                    it.index = '0;
      end else if (r < 95) begin
        it.index = IDX_W'($urandom_range(0, CAP));
      end else begin
        it.index = IDX_W'($urandom_range(0, IDX_MAX));
      end

      r = $urandom_range(0, 99);
      if      (r < 70) it.new_length = IDX_W'($urandom_range(0, 16));
      else if (r < 85) it.new_length = IDX_W'($urandom_range(0, CAP));
      else if (r < 92) it.new_length = IDX_W'(CAP);
      else             it.new_length = IDX_W'($urandom_range(CAP + 1, IDX_MAX));

      r = $urandom_range(0, 99);
      if      (r < 10) it.value = '0;
      else if (r < 20) it.value = ALL_ONES;
      else             it.value = $urandom;

      op_backlog.insert(op_backlog.size(), it);
    end

    // wait for the last transaction to go in and every reply to come back
    while (op_backlog.size() != 0 || in_valid) @(negedge clk);
    while (reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: indexed_insert_erase_array.f
+incdir+sv
sv/iiea_pkg.sv
sv/iiea_cell.sv
sv/indexed_insert_erase_array.sv
sv/iiea_checker.sv
tb/tb_indexed_insert_erase_array.sv
